[rtl/mrq_pkg.sv]
// Shared types, codes and constants of the message retry queue.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mrq_pkg;

   // Default sizes of the two queues.
   localparam int QUEUE_DEPTH_DEF = 5;
   localparam int MAX_PAYLOAD_DEF = 46;

   // Incoming frame layout: id, length, data length, data, sequence, retry.
   localparam int IN_OVERHEAD    = 5;
   localparam int IN_DATA_OFFSET = 3;
   localparam int IN_MIN_LEN     = 4;
   localparam int LEN_ADJUST     = 2;

   // Length byte offsets of the emitted frames.
   localparam logic [7:0] READ_LEN_EXTRA = 8'd7;
   localparam logic [7:0] SEND_LEN_EXTRA = 8'd3;

   localparam logic [7:0] RETRY_LIMIT_RESET = 8'd3;

   // Depth of the command queue between front and back.
   localparam int CMD_FIFO_DEPTH = 2;

   typedef enum logic [1:0] {
      REQ_IN_BYTE  = 2'd0,
      REQ_READ_IN  = 2'd1,
      REQ_OUT_BYTE = 2'd2,
      REQ_SEND_OUT = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_BYTE    = 2'd0,
      ST_STORED  = 2'd1,
      ST_INVALID = 2'd2,
      ST_EMPTY   = 2'd3
   } status_code_type;

   typedef enum logic [1:0] {
      CSR_FRAME_ID    = 2'd0,
      CSR_TS_FRAME_ID = 2'd1,
      CSR_RETRY_LIMIT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [31:0] now_time;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic [1:0] status;
      logic [2:0] incoming_count;
      logic [2:0] outgoing_count;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0] frame_id;
      logic [7:0] ts_frame_id;
      logic [7:0] retry_limit;
   } cfg_type;

   // One classified request handed from the front to the back.
   typedef struct packed {
      req_code_type kind;
      logic         ok;
      logic [7:0]   len;
      logic [7:0]   seq;
      logic [7:0]   retry;
      logic [31:0]  stamp;
   } cmd_type;

endpackage

`default_nettype wire

[rtl/message_retry_queue_top.sv]
// Message retry queue top level: configuration registers, front end,
// command queue and back end. A stored frame gives its status beat after
// its payload is copied from staging, one byte a cycle. A read or send emits
// its frame beats by alternating states S_RD and S_WR, holding while the
// result beat is stalled. A non-final byte is taken every cycle unless the
// front stalls. Synchronous reset empties both queues and loads defaults.
`default_nettype none

module message_retry_queue_top #(
   parameter int QUEUE_DEPTH = mrq_pkg::QUEUE_DEPTH_DEF,
   parameter int MAX_PAYLOAD = mrq_pkg::MAX_PAYLOAD_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  mrq_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output mrq_pkg::rsp_item_type rsp_data,
   input  wire                   csr_we,
   input  wire [1:0]             csr_index,
   input  wire [7:0]             csr_wdata
);
   import mrq_pkg::*;

   localparam int SAW = $clog2(MAX_PAYLOAD + IN_OVERHEAD);

   cfg_type        cfg_ff;
   logic           cmd_push, cmd_full, cmd_pop, cmd_valid, stg_release;
   cmd_type        push_cmd, pop_cmd;
   logic [SAW-1:0] stg_rd_addr;
   logic [7:0]     stg_rd_data;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_id    <= 8'd0;
         cfg_ff.ts_frame_id <= 8'd0;
         cfg_ff.retry_limit <= RETRY_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRAME_ID:    cfg_ff.frame_id    <= csr_wdata;
            CSR_TS_FRAME_ID: cfg_ff.ts_frame_id <= csr_wdata;
            CSR_RETRY_LIMIT: cfg_ff.retry_limit <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   mrq_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .cfg         (cfg_ff),
      .cmd_push    (cmd_push),
      .cmd_data    (push_cmd),
      .cmd_full    (cmd_full),
      .stg_release (stg_release),
      .stg_rd_addr (stg_rd_addr),
      .stg_rd_data (stg_rd_data)
   );

   mrq_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (push_cmd),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_valid (cmd_valid),
      .pop_data  (pop_cmd)
   );

   mrq_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .cmd_valid   (cmd_valid),
      .cmd_data    (pop_cmd),
      .cmd_pop     (cmd_pop),
      .stg_rd_addr (stg_rd_addr),
      .stg_rd_data (stg_rd_data),
      .stg_release (stg_release),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

[rtl/mrq_front.sv]
// Front end: accepts request beats, fills the staging buffer and classifies
// each completed request into a command. Depends on mrq_pkg.
`default_nettype none

module mrq_front #(
   parameter int MAX_PAYLOAD = mrq_pkg::MAX_PAYLOAD_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  mrq_pkg::req_item_type req_data,
   input  mrq_pkg::cfg_type     cfg,
   output logic                 cmd_push,
   output mrq_pkg::cmd_type     cmd_data,
   input  wire                  cmd_full,
   input  wire                  stg_release,
   input  wire [$clog2(MAX_PAYLOAD + mrq_pkg::IN_OVERHEAD)-1:0] stg_rd_addr,
   output logic [7:0]           stg_rd_data
);
   import mrq_pkg::*;

   localparam int STAGE = MAX_PAYLOAD + IN_OVERHEAD;
   localparam int SAW   = $clog2(STAGE);
   localparam int PW    = $clog2(STAGE + 1);

   logic [7:0]    stg_mem [STAGE];
   logic [7:0]    stg_rd_ff;
   logic [PW-1:0] pos_ff;
   logic          ovf_ff;
   logic          hold_ff;
   logic [7:0]    b0_ff, b1_ff, b2_ff, seq_ff, ret_ff;

   logic          accept, is_byte, room, wr;
   logic [8:0]    pos9, len_eff, seq_pos, ret_pos;
   logic          ovf_eff, in_ok, out_ok;
   logic [7:0]    ret_eff;

   // The front stalls while a stored frame still waits to be copied out or the command queue is full.
   assign req_ready = !hold_ff && !cmd_full;
   assign accept    = req_valid && req_ready;
   assign is_byte   = (req_data.req_type == REQ_IN_BYTE) ||
                      (req_data.req_type == REQ_OUT_BYTE);
   assign room      = pos_ff < PW'(STAGE);
   assign wr        = accept && is_byte && room;

   assign pos9    = 9'(pos_ff);
   assign seq_pos = 9'(b2_ff) + 9'(IN_DATA_OFFSET);
   assign ret_pos = seq_pos + 9'd1;
   assign len_eff = room ? pos9 + 9'd1 : pos9;
   assign ovf_eff = ovf_ff || !room;
   assign ret_eff = (wr && pos9 == ret_pos) ? req_data.data_byte : ret_ff;

   // Frame checks, evaluated on the last beat of a stored frame.
   assign in_ok  = !ovf_eff && (len_eff >= 9'(IN_MIN_LEN)) &&
                   (b0_ff == cfg.frame_id) &&
                   (9'(b1_ff) + 9'(LEN_ADJUST) == len_eff) &&
                   (9'(b2_ff) <= 9'(MAX_PAYLOAD)) &&
                   (9'(b2_ff) + 9'(IN_OVERHEAD) <= len_eff);
   assign out_ok = !ovf_eff && (len_eff <= 9'(MAX_PAYLOAD));

   // Command built from the accepted beat.
   always_comb begin
      cmd_data.kind  = req_code_type'(req_data.req_type);
      cmd_data.seq   = seq_ff;
      cmd_data.retry = ret_eff;
      cmd_data.stamp = req_data.now_time;
      case (req_data.req_type)
         REQ_IN_BYTE: begin
            cmd_data.ok  = in_ok;
            cmd_data.len = b2_ff;
         end
         REQ_OUT_BYTE: begin
            cmd_data.ok  = out_ok;
            cmd_data.len = len_eff[7:0];
         end
         default: begin
            cmd_data.ok  = 1'b1;
            cmd_data.len = 8'd0;
         end
      endcase
   end

   assign cmd_push = accept && (!is_byte || req_data.last_byte);

   // Staging memory with a registered read port for the back end.
   always_ff @(posedge clock) begin
      if (wr) begin
         stg_mem[pos_ff[SAW-1:0]] <= req_data.data_byte;
      end
      stg_rd_ff <= stg_mem[stg_rd_addr];
   end
   assign stg_rd_data = stg_rd_ff;

   // Header and trailer bytes are captured as they pass.
   always_ff @(posedge clock) begin
      if (wr) begin
         if (pos9 == 9'd0) b0_ff <= req_data.data_byte;
         if (pos9 == 9'd1) b1_ff <= req_data.data_byte;
         if (pos9 == 9'd2) b2_ff <= req_data.data_byte;
         if (pos9 == seq_pos) seq_ff <= req_data.data_byte;
         if (pos9 == ret_pos) ret_ff <= req_data.data_byte;
      end
   end

   // Staging position, overflow and hold flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         ovf_ff  <= 1'b0;
         hold_ff <= 1'b0;
      end else begin
         if (accept && is_byte) begin
            if (req_data.last_byte) begin
               pos_ff <= '0;
               ovf_ff <= 1'b0;
            end else if (room) begin
               pos_ff <= pos_ff + PW'(1);
            end else begin
               ovf_ff <= 1'b1;
            end
         end
         if (stg_release) begin
            hold_ff <= 1'b0;
         end else if (cmd_push && is_byte && cmd_data.ok) begin
            hold_ff <= 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

[rtl/mrq_cmd_fifo.sv]
// Two-entry command queue that decouples the front end from the back end.
// Depends on mrq_pkg.
`default_nettype none

module mrq_cmd_fifo (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  mrq_pkg::cmd_type push_data,
   output logic             full,
   input  wire              pop,
   output logic             pop_valid,
   output mrq_pkg::cmd_type pop_data
);
   import mrq_pkg::*;

   localparam int AW = $clog2(CMD_FIFO_DEPTH);
   localparam int CW = $clog2(CMD_FIFO_DEPTH + 1);

   cmd_type       slot_ff [CMD_FIFO_DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [CW-1:0] cnt_ff;

   assign full      = cnt_ff == CW'(CMD_FIFO_DEPTH);
   assign pop_valid = cnt_ff != '0;
   assign pop_data  = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   // Pointers wrap naturally at the power-of-two depth.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + AW'(1);
         if (pop)  rd_ff <= rd_ff + AW'(1);
         if (push && !pop) begin
            cnt_ff <= cnt_ff + CW'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
      end
   end

endmodule

`default_nettype wire

[rtl/mrq_back.sv]
// Back end: carries out commands on the two queues and emits result beats.
// Holds queue entries and payload memories. Depends on mrq_pkg.
`default_nettype none

module mrq_back #(
   parameter int QUEUE_DEPTH = mrq_pkg::QUEUE_DEPTH_DEF,
   parameter int MAX_PAYLOAD = mrq_pkg::MAX_PAYLOAD_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  mrq_pkg::cfg_type     cfg,
   input  wire                  cmd_valid,
   input  mrq_pkg::cmd_type     cmd_data,
   output logic                 cmd_pop,
   output logic [$clog2(MAX_PAYLOAD + mrq_pkg::IN_OVERHEAD)-1:0] stg_rd_addr,
   input  wire [7:0]            stg_rd_data,
   output logic                 stg_release,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output mrq_pkg::rsp_item_type rsp_data
);
   import mrq_pkg::*;

   localparam int SW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int MSIZE = QUEUE_DEPTH * MAX_PAYLOAD;
   localparam int MW    = (MSIZE > 1) ? $clog2(MSIZE) : 1;
   localparam int STAGE = MAX_PAYLOAD + IN_OVERHEAD;
   localparam int SAW   = $clog2(STAGE);

   typedef struct packed {
      logic [SW-1:0] slot;
      logic [7:0]    len;
      logic [7:0]    seq;
      logic [7:0]    retry;
      logic [31:0]   stamp;
   } in_meta_type;

   typedef struct packed {
      logic [SW-1:0] slot;
      logic [7:0]    len;
      logic [7:0]    seq;
      logic [7:0]    retry;
   } out_meta_type;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_MATCH  = 10'b0000000010,
      S_FULL   = 10'b0000000100,
      S_ALLOC  = 10'b0000001000,
      S_COPY   = 10'b0000010000,
      S_COMMIT = 10'b0000100000,
      S_STATUS = 10'b0001000000,
      S_RD     = 10'b0010000000,
      S_WR     = 10'b0100000000,
      S_FIN    = 10'b1000000000
   } state_type;

   state_type     state_ff;
   cmd_type       cmd_ff;
   in_meta_type   in_meta_ff  [QUEUE_DEPTH];
   out_meta_type  out_meta_ff [QUEUE_DEPTH];
   logic [CW-1:0] in_cnt_ff, out_cnt_ff;
   logic [SW-1:0] send_idx_ff, idx_ff, slot_ff, e_slot_ff;
   logic [7:0]    seq_ctr_ff, e_len_ff, e_seq_ff, e_retry_ff;
   logic [31:0]   e_stamp_ff;
   logic          drop_ff;
   logic [CW-1:0] disp_in_ff, disp_out_ff;
   status_code_type status_ff;
   logic [8:0]    k_ff;
   logic [7:0]    c_ff, wc_ff;
   logic          wv_ff;
   logic          rsp_valid_ff;
   rsp_item_type  rsp_ff;

   logic [7:0]    in_pay  [MSIZE];
   logic [7:0]    out_pay [MSIZE];
   logic [7:0]    in_rd_ff, out_rd_ff;

   logic          out_free, is_read;
   logic          hit;
   logic [SW-1:0] hit_idx;
   logic [QUEUE_DEPTH-1:0] used;
   logic [SW-1:0] free_slot;
   logic          in_drop, out_drop;
   logic [SW-1:0] in_drop_idx, out_drop_idx;
   logic [SW-1:0] sidx;
   logic [7:0]    new_retry;
   logic          issue;
   logic [MW-1:0] rd_addr, wr_addr;
   logic [8:0]    len9, last_k, tail_k;
   logic          is_data;
   logic [7:0]    data_off, sel_byte;
   logic [1:0]    stamp_sel;
   logic [CW-1:0] base_idx, new_cnt;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign is_read     = cmd_ff.kind == REQ_READ_IN;
   assign cmd_pop     = (state_ff == S_IDLE) && cmd_valid;
   assign stg_release = state_ff == S_COMMIT;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_ff;

   // First stored incoming entry with the new frame's sequence number.
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
         if (!hit && CW'(j) < in_cnt_ff && in_meta_ff[j].seq == cmd_ff.seq) begin
            hit     = 1'b1;
            hit_idx = SW'(j);
         end
      end
   end

   // Lowest payload slot not held by a live entry of the target queue.
   always_comb begin
      used      = '0;
      free_slot = '0;
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
         if (cmd_ff.kind == REQ_IN_BYTE) begin
            if (CW'(j) < in_cnt_ff) used[in_meta_ff[j].slot] = 1'b1;
         end else begin
            if (CW'(j) < out_cnt_ff) used[out_meta_ff[j].slot] = 1'b1;
         end
      end
      for (int j = QUEUE_DEPTH - 1; j >= 0; j--) begin
         if (!used[j]) free_slot = SW'(j);
      end
   end

   // Entry removal requests; the entries behind move up by one.
   always_comb begin
      in_drop      = 1'b0;
      in_drop_idx  = '0;
      out_drop     = 1'b0;
      out_drop_idx = '0;
      case (state_ff)
         S_MATCH: begin
            in_drop     = hit;
            in_drop_idx = hit_idx;
         end
         S_FULL: begin
            if (cmd_ff.kind == REQ_IN_BYTE) begin
               in_drop = in_cnt_ff == CW'(QUEUE_DEPTH);
            end else begin
               out_drop = out_cnt_ff == CW'(QUEUE_DEPTH);
            end
         end
         S_FIN: begin
            if (is_read) begin
               in_drop = 1'b1;
            end else begin
               out_drop     = drop_ff;
               out_drop_idx = idx_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Send entry selection and its new retry count.
   assign sidx      = (CW'(send_idx_ff) >= out_cnt_ff) ? '0 : send_idx_ff;
   assign new_retry = out_meta_ff[sidx].retry + 8'd1;

   // Payload copy from staging: read issue, then write in the following cycle.
   assign issue       = (state_ff == S_COPY) && (c_ff < cmd_ff.len);
   assign stg_rd_addr = SAW'(9'(c_ff) +
                        ((cmd_ff.kind == REQ_IN_BYTE) ? 9'(IN_DATA_OFFSET) : 9'd0));
   assign wr_addr     = MW'(slot_ff * MAX_PAYLOAD) + MW'(wc_ff);

   // Frame byte selection for the emitted frame.
   assign len9      = 9'(e_len_ff);
   assign last_k    = len9 + (is_read ? 9'd8 : 9'd4);
   assign tail_k    = k_ff - len9 - 9'(IN_OVERHEAD);
   assign stamp_sel = tail_k[1:0];
   assign is_data   = (k_ff >= 9'(IN_DATA_OFFSET)) &&
                      (k_ff < len9 + 9'(IN_DATA_OFFSET));
   assign data_off  = is_data ? 8'(k_ff - 9'(IN_DATA_OFFSET)) : 8'd0;
   assign rd_addr   = MW'(e_slot_ff * MAX_PAYLOAD) + MW'(data_off);

   always_comb begin
      if (k_ff == 9'd0) begin
         sel_byte = is_read ? cfg.ts_frame_id : cfg.frame_id;
      end else if (k_ff == 9'd1) begin
         sel_byte = e_len_ff + (is_read ? READ_LEN_EXTRA : SEND_LEN_EXTRA);
      end else if (k_ff == 9'd2) begin
         sel_byte = e_len_ff;
      end else if (is_data) begin
         sel_byte = is_read ? in_rd_ff : out_rd_ff;
      end else if (k_ff == len9 + 9'(IN_DATA_OFFSET)) begin
         sel_byte = e_seq_ff;
      end else if (k_ff == len9 + 9'(IN_DATA_OFFSET) + 9'd1) begin
         sel_byte = e_retry_ff;
      end else begin
         sel_byte = e_stamp_ff[8 * stamp_sel +: 8];
      end
   end

   // Send index after the send: stays on a removed entry, else advances.
   assign base_idx = drop_ff ? CW'(idx_ff) : CW'(idx_ff) + CW'(1);
   assign new_cnt  = out_cnt_ff - CW'(drop_ff);

   // Payload memories, one write and one registered read port each.
   always_ff @(posedge clock) begin
      if (wv_ff && cmd_ff.kind == REQ_IN_BYTE) begin
         in_pay[wr_addr] <= stg_rd_data;
      end
      in_rd_ff <= in_pay[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wv_ff && cmd_ff.kind == REQ_OUT_BYTE) begin
         out_pay[wr_addr] <= stg_rd_data;
      end
      out_rd_ff <= out_pay[rd_addr];
   end

   // Queue entries: removal shifts, commit appends, send updates retry.
   always_ff @(posedge clock) begin
      if (in_drop) begin
         for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
            if (SW'(j) >= in_drop_idx) in_meta_ff[j] <= in_meta_ff[j + 1];
         end
      end
      if (out_drop) begin
         for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
            if (SW'(j) >= out_drop_idx) out_meta_ff[j] <= out_meta_ff[j + 1];
         end
      end
      if (state_ff == S_COMMIT) begin
         if (cmd_ff.kind == REQ_IN_BYTE) begin
            in_meta_ff[in_cnt_ff[SW-1:0]] <= '{slot: slot_ff, len: cmd_ff.len,
               seq: cmd_ff.seq, retry: cmd_ff.retry, stamp: cmd_ff.stamp};
         end else begin
            out_meta_ff[out_cnt_ff[SW-1:0]] <= '{slot: slot_ff, len: cmd_ff.len,
               seq: seq_ctr_ff + 8'd1, retry: 8'd0};
         end
      end
      if (cmd_pop && cmd_data.kind == REQ_SEND_OUT && out_cnt_ff != '0) begin
         out_meta_ff[sidx].retry <= new_retry;
      end
   end

   // Working registers of the current command.
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cmd_ff <= cmd_data;
         k_ff   <= '0;
         if (cmd_data.kind == REQ_READ_IN) begin
            e_slot_ff  <= in_meta_ff[0].slot;
            e_len_ff   <= in_meta_ff[0].len;
            e_seq_ff   <= in_meta_ff[0].seq;
            e_retry_ff <= in_meta_ff[0].retry;
            e_stamp_ff <= in_meta_ff[0].stamp;
            disp_in_ff  <= in_cnt_ff - CW'(1);
            disp_out_ff <= out_cnt_ff;
         end else begin
            e_slot_ff  <= out_meta_ff[sidx].slot;
            e_len_ff   <= out_meta_ff[sidx].len;
            e_seq_ff   <= out_meta_ff[sidx].seq;
            e_retry_ff <= new_retry;
            idx_ff     <= sidx;
            drop_ff    <= new_retry >= cfg.retry_limit;
            disp_in_ff  <= in_cnt_ff;
            disp_out_ff <= out_cnt_ff - CW'(new_retry >= cfg.retry_limit);
         end
      end
      if (state_ff == S_WR && out_free) begin
         k_ff <= k_ff + 9'd1;
      end
      if (state_ff == S_ALLOC) begin
         slot_ff <= free_slot;
         c_ff    <= 8'd0;
      end else if (issue) begin
         c_ff <= c_ff + 8'd1;
      end
      wc_ff <= c_ff;
   end

   // Sequencer, counts and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_cnt_ff    <= '0;
         out_cnt_ff   <= '0;
         send_idx_ff  <= '0;
         seq_ctr_ff   <= 8'd0;
         wv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= ST_BYTE;
      end else begin
         wv_ff <= issue;
         if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (in_drop)  in_cnt_ff  <= in_cnt_ff - CW'(1);
         if (out_drop) out_cnt_ff <= out_cnt_ff - CW'(1);
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  case (cmd_data.kind)
                     REQ_IN_BYTE: begin
                        status_ff <= ST_INVALID;
                        state_ff  <= cmd_data.ok ? S_MATCH : S_STATUS;
                     end
                     REQ_OUT_BYTE: begin
                        status_ff <= ST_INVALID;
                        state_ff  <= cmd_data.ok ? S_FULL : S_STATUS;
                     end
                     REQ_READ_IN: begin
                        status_ff <= ST_EMPTY;
                        state_ff  <= (in_cnt_ff == '0) ? S_STATUS : S_RD;
                     end
                     default: begin
                        status_ff <= ST_EMPTY;
                        state_ff  <= (out_cnt_ff == '0) ? S_STATUS : S_RD;
                     end
                  endcase
               end
            end
            S_MATCH: state_ff <= S_FULL;
            S_FULL:  state_ff <= S_ALLOC;
            S_ALLOC: state_ff <= S_COPY;
            S_COPY: begin
               if (!issue && !wv_ff) state_ff <= S_COMMIT;
            end
            S_COMMIT: begin
               if (cmd_ff.kind == REQ_IN_BYTE) begin
                  in_cnt_ff <= in_cnt_ff + CW'(1);
               end else begin
                  out_cnt_ff <= out_cnt_ff + CW'(1);
                  seq_ctr_ff <= seq_ctr_ff + 8'd1;
               end
               status_ff <= ST_STORED;
               state_ff  <= S_STATUS;
            end
            S_STATUS: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{out_byte: 8'd0, out_last: 1'b1, status: status_ff,
                     incoming_count: 3'(in_cnt_ff), outgoing_count: 3'(out_cnt_ff)};
                  state_ff <= S_IDLE;
               end
            end
            S_RD: state_ff <= S_WR;
            S_WR: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{out_byte: sel_byte, out_last: k_ff == last_k,
                     status: ST_BYTE, incoming_count: 3'(disp_in_ff),
                     outgoing_count: 3'(disp_out_ff)};
                  state_ff <= (k_ff == last_k) ? S_FIN : S_RD;
               end
            end
            S_FIN: begin
               if (!is_read) begin
                  send_idx_ff <= (base_idx >= new_cnt) ? '0 : base_idx[SW-1:0];
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

[rtl/mrq_checker.sv]
// Port-level checks on the result channel of the message retry queue,
// bound to the top level. Depends on mrq_pkg.
`default_nettype none

module mrq_checker #(
   parameter int QUEUE_DEPTH = mrq_pkg::QUEUE_DEPTH_DEF
) (
   input wire                   clock,
   input wire                   reset,
   input wire                   rsp_valid,
   input wire                   rsp_ready,
   input mrq_pkg::rsp_item_type rsp_data
);
   import mrq_pkg::*;

   // A stalled result beat stays offered.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // A status beat is always the only and last beat of its request.
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_BYTE |-> rsp_data.out_last)
      else $error("status beat not marked last");

   // Status beats carry no frame byte.
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_BYTE |-> rsp_data.out_byte == 8'd0)
      else $error("status beat with nonzero byte");

   // Queue occupancy never exceeds the depth.
   a_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.incoming_count) <= QUEUE_DEPTH) &&
                    (32'(rsp_data.outgoing_count) <= QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule

bind message_retry_queue_top mrq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (.*);

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for message_retry_queue_top: directed and random frames
// are checked against a behavioral predictor of both queues.
// Depends on mrq_pkg and the message_retry_queue_top RTL.
`timescale 1ns / 100ps

module testbench;
   import mrq_pkg::*;

   localparam int DEPTH       = QUEUE_DEPTH_DEF;
   localparam int PAYLOAD_MAX = MAX_PAYLOAD_DEF;
   localparam int STAGE_LEN   = PAYLOAD_MAX + IN_OVERHEAD;
   localparam int STALL_LIMIT = 3000;
   localparam int SETTLE      = 80;

   typedef struct {
      logic [7:0]  len;
      logic [7:0]  seq;
      logic [7:0]  retry;
      logic [31:0] stamp;
      logic [7:0]  data [PAYLOAD_MAX];
   } entry_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_data;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [7:0]   csr_wdata = '0;

   // Predictor state.
   logic [7:0]   mdl_frame_id, mdl_ts_id, mdl_retry_limit;
   logic [7:0]   stage [STAGE_LEN];
   int           stage_pos;
   bit           stage_ovf;
   entry_type    in_queue [$];
   entry_type    out_queue [$];
   int           send_ptr;
   logic [7:0]   seq_ctr;

   rsp_item_type expected_beats [$];
   logic [7:0]   frame_buf [$];
   int           error_count = 0;
   int           item_count = 0;
   bit           idle_on = 1'b0;
   int           rsp_burst = 0;
   int           stall_cycles = 0;

   message_retry_queue_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Commit an incoming frame from staging; returns the status.
   function automatic logic [1:0] commit_in(logic [31:0] now);
      entry_type e;
      int dl;
      if (stage_ovf || stage_pos < IN_MIN_LEN || stage[0] != mdl_frame_id ||
          int'(stage[1]) + LEN_ADJUST != stage_pos)
         return ST_INVALID;
      dl = stage[2];
      if (dl > PAYLOAD_MAX || dl + IN_OVERHEAD > stage_pos) return ST_INVALID;
      foreach (in_queue[i]) begin
         if (in_queue[i].seq == stage[IN_DATA_OFFSET + dl]) begin
            in_queue.delete(i);
            break;
         end
      end
      if (in_queue.size() >= DEPTH) in_queue.delete(0);
      e.len = dl;
      for (int i = 0; i < PAYLOAD_MAX; i++)
         e.data[i] = (i < dl) ? stage[IN_DATA_OFFSET + i] : 8'h00;
      e.seq   = stage[IN_DATA_OFFSET + dl];
      e.retry = stage[IN_DATA_OFFSET + dl + 1];
      e.stamp = now;
      in_queue.push_back(e);
      return ST_STORED;
   endfunction

   // Commit an outgoing payload from staging; returns the status.
   function automatic logic [1:0] commit_out();
      entry_type e;
      if (stage_ovf || stage_pos > PAYLOAD_MAX) return ST_INVALID;
      if (out_queue.size() >= DEPTH) out_queue.delete(0);
      seq_ctr = seq_ctr + 8'd1;
      e.len = stage_pos;
      for (int i = 0; i < PAYLOAD_MAX; i++)
         e.data[i] = (i < stage_pos) ? stage[i] : 8'h00;
      e.seq   = seq_ctr;
      e.retry = 8'd0;
      e.stamp = '0;
      out_queue.push_back(e);
      return ST_STORED;
   endfunction

   // Work out the beats that one accepted request causes.
   function automatic void predict_beats(req_item_type r);
      rsp_item_type beats [$];
      rsp_item_type b;
      entry_type e;
      b = '0;
      if (r.req_type == REQ_IN_BYTE || r.req_type == REQ_OUT_BYTE) begin
         if (stage_pos < STAGE_LEN) begin
            stage[stage_pos] = r.data_byte;
            stage_pos++;
         end else begin
            stage_ovf = 1'b1;
         end
         if (!r.last_byte) return;
         b.status = (r.req_type == REQ_IN_BYTE) ? commit_in(r.now_time) : commit_out();
         beats.push_back(b);
         stage_pos = 0;
         stage_ovf = 1'b0;
      end else if (r.req_type == REQ_READ_IN) begin
         if (in_queue.size() == 0) begin
            b.status = ST_EMPTY;
            beats.push_back(b);
         end else begin
            e = in_queue.pop_front();
            b.status = ST_BYTE;
            b.out_byte = mdl_ts_id;            beats.push_back(b);
            b.out_byte = e.len + READ_LEN_EXTRA; beats.push_back(b);
            b.out_byte = e.len;                beats.push_back(b);
            for (int i = 0; i < e.len; i++) begin
               b.out_byte = e.data[i];
               beats.push_back(b);
            end
            b.out_byte = e.seq;   beats.push_back(b);
            b.out_byte = e.retry; beats.push_back(b);
            for (int i = 0; i < 4; i++) begin
               b.out_byte = e.stamp[8*i +: 8];
               beats.push_back(b);
            end
         end
      end else begin
         if (out_queue.size() == 0) begin
            b.status = ST_EMPTY;
            beats.push_back(b);
         end else begin
            if (send_ptr >= out_queue.size()) send_ptr = 0;
            out_queue[send_ptr].retry = out_queue[send_ptr].retry + 8'd1;
            e = out_queue[send_ptr];
            b.status = ST_BYTE;
            b.out_byte = mdl_frame_id;           beats.push_back(b);
            b.out_byte = e.len + SEND_LEN_EXTRA; beats.push_back(b);
            b.out_byte = e.len;                  beats.push_back(b);
            for (int i = 0; i < e.len; i++) begin
               b.out_byte = e.data[i];
               beats.push_back(b);
            end
            b.out_byte = e.seq;   beats.push_back(b);
            b.out_byte = e.retry; beats.push_back(b);
            if (e.retry >= mdl_retry_limit) out_queue.delete(send_ptr);
            else send_ptr++;
            if (send_ptr >= out_queue.size()) send_ptr = 0;
         end
      end
      // Counts reflect the queues after the whole request.
      foreach (beats[k]) begin
         beats[k].out_last       = (k == beats.size() - 1);
         beats[k].incoming_count = in_queue.size();
         beats[k].outgoing_count = out_queue.size();
         expected_beats.push_back(beats[k]);
      end
   endfunction

   // Drive one request beat and wait for it to be accepted.
   task automatic send_item(logic [1:0] kind, logic [7:0] value, logic last);
      int gap;
      @(negedge clock);
      req_valid = 1'b1;
      req_data.req_type  = kind;
      req_data.data_byte = value;
      req_data.last_byte = last;
      req_data.now_time  = $urandom;
      do @(posedge clock); while (!req_ready);
      predict_beats(req_data);
      item_count++;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Lower the request valid and wait until every expected beat is back.
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [7:0] value);
      wait_drained();
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      case (idx)
         CSR_FRAME_ID:    mdl_frame_id = value;
         CSR_TS_FRAME_ID: mdl_ts_id = value;
         default:         mdl_retry_limit = value;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Send the bytes of frame_buf as one frame of the given kind.
   task automatic send_frame(logic [1:0] kind);
      foreach (frame_buf[i]) send_item(kind, frame_buf[i], i == frame_buf.size() - 1);
   endtask

   task automatic build_in_frame(int dl, logic [7:0] seq);
      frame_buf = {};
      frame_buf.push_back(mdl_frame_id);
      frame_buf.push_back(dl + 3);
      frame_buf.push_back(dl);
      repeat (dl) frame_buf.push_back($urandom);
      frame_buf.push_back(seq);
      frame_buf.push_back($urandom);
   endtask

   task automatic build_payload(int n);
      frame_buf = {};
      repeat (n) frame_buf.push_back($urandom);
   endtask

   // Extremes, each frame check, empty queues, replacement and eviction.
   task automatic test_directed();
      write_reg(CSR_FRAME_ID, 8'hFF);
      write_reg(CSR_TS_FRAME_ID, 8'h00);
      write_reg(CSR_RETRY_LIMIT, 8'd1);
      send_item(REQ_READ_IN, 8'h00, 1'b0);
      send_item(REQ_SEND_OUT, 8'hFF, 1'b1);
      build_in_frame(0, 8'h00); send_frame(REQ_IN_BYTE);
      build_in_frame(PAYLOAD_MAX, 8'hFF); send_frame(REQ_IN_BYTE);
      build_in_frame(2, 8'h00); send_frame(REQ_IN_BYTE);        // same sequence replaces
      build_in_frame(1, 8'h11); frame_buf = frame_buf[0:2]; send_frame(REQ_IN_BYTE);
      build_in_frame(1, 8'h12); frame_buf[0] = 8'h00; send_frame(REQ_IN_BYTE);
      build_in_frame(1, 8'h13); frame_buf[1] = 8'h07; send_frame(REQ_IN_BYTE);
      build_in_frame(3, 8'h14); frame_buf[2] = 8'd47; send_frame(REQ_IN_BYTE);
      build_in_frame(3, 8'h15); frame_buf[2] = 8'd4; send_frame(REQ_IN_BYTE);
      build_payload(STAGE_LEN + 2); send_frame(REQ_IN_BYTE);     // staging overflow
      for (int i = 0; i < DEPTH + 1; i++) begin
         build_in_frame(i, 8'h40 + i); send_frame(REQ_IN_BYTE);
      end
      repeat (DEPTH + 1) send_item(REQ_READ_IN, $urandom, $urandom);
      build_payload(PAYLOAD_MAX); send_frame(REQ_OUT_BYTE);
      build_payload(PAYLOAD_MAX + 1); send_frame(REQ_OUT_BYTE);
      build_payload(STAGE_LEN + 1); send_frame(REQ_OUT_BYTE);
      build_in_frame(1, 8'h20); send_frame(REQ_OUT_BYTE);        // mixed kinds
      build_in_frame(2, 8'h21);
      send_item(REQ_OUT_BYTE, frame_buf[0], 1'b0);
      frame_buf.delete(0);
      send_frame(REQ_IN_BYTE);
      for (int i = 0; i < DEPTH + 1; i++) begin
         build_payload(1 + i); send_frame(REQ_OUT_BYTE);
      end
      repeat (DEPTH + 2) send_item(REQ_SEND_OUT, $urandom, $urandom);
   endtask

   // Mostly well-formed frames with random content, some noise.
   task automatic random_request();
      int pick;
      int n;
      pick = $urandom_range(0, 19);
      if (pick < 6) begin
         build_in_frame($urandom_range(0, 3) == 0 ? $urandom_range(0, PAYLOAD_MAX)
                                                  : $urandom_range(0, 6),
                        $urandom_range(0, 7));
         if (pick == 0) frame_buf[$urandom_range(0, frame_buf.size() - 1)] = $urandom;
         send_frame(REQ_IN_BYTE);
      end else if (pick < 10) begin
         build_payload($urandom_range(0, 7) == 0 ? $urandom_range(1, STAGE_LEN + 2)
                                                 : $urandom_range(1, 6));
         send_frame(REQ_OUT_BYTE);
      end else if (pick < 13) begin
         send_item(REQ_READ_IN, $urandom, $urandom);
      end else if (pick < 18) begin
         send_item(REQ_SEND_OUT, $urandom, $urandom);
      end else begin
         n = $urandom_range(1, 8);
         for (int i = 0; i < n; i++)
            send_item($urandom_range(0, 1) ? REQ_IN_BYTE : REQ_OUT_BYTE, $urandom,
                      i == n - 1);
      end
   endtask

   task automatic test_random(int target);
      while (item_count < target) random_request();
   endtask

   // Sender holds back until the block has answered everything.
   task automatic test_drain_pause();
      build_in_frame(4, 8'h05); send_frame(REQ_IN_BYTE);
      build_payload(3); send_frame(REQ_OUT_BYTE);
      wait_drained();
      send_item(REQ_READ_IN, 8'h00, 1'b0);
      send_item(REQ_SEND_OUT, 8'h00, 1'b0);
   endtask

   // Result checker.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected beat %h", $time, rsp_data);
            error_count++;
         end else begin
            want = expected_beats.pop_front();
            if (rsp_data.out_byte !== want.out_byte ||
                rsp_data.out_last !== want.out_last ||
                rsp_data.status !== want.status ||
                rsp_data.incoming_count !== want.incoming_count ||
                rsp_data.outgoing_count !== want.outgoing_count) begin
               $display("%0t: mismatch expected byte %h last %b status %0d in %0d out %0d",
                        $time, want.out_byte, want.out_last, want.status,
                        want.incoming_count, want.outgoing_count);
               $display("%0t:          actual   byte %h last %b status %0d in %0d out %0d",
                        $time, rsp_data.out_byte, rsp_data.out_last, rsp_data.status,
                        rsp_data.incoming_count, rsp_data.outgoing_count);
               error_count++;
            end
         end
      end
   end

   // Receiver stalls in random bursts.
   always @(negedge clock) begin
      if (rsp_burst > 0) begin
         rsp_ready = 1'b0;
         rsp_burst--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_ready = 1'b0;
         rsp_burst = $urandom_range(0, 5);
      end else begin
         rsp_ready = 1'b1;
      end
   end

   // Watchdog on cycles with no beat moving.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles = 0;
      else if (++stall_cycles >= STALL_LIMIT) begin
         $display("message_retry_queue_top test failed");
         $finish;
      end
   end

   initial begin
      mdl_frame_id = 8'h00;
      mdl_ts_id = 8'h00;
      mdl_retry_limit = RETRY_LIMIT_RESET;
      stage_pos = 0;
      stage_ovf = 1'b0;
      send_ptr = 0;
      seq_ctr = 8'h00;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      idle_on = 1'b1;
      test_directed();
      test_drain_pause();
      write_reg(CSR_RETRY_LIMIT, 8'd3);
      write_reg(CSR_FRAME_ID, $urandom);
      write_reg(CSR_TS_FRAME_ID, 8'hFF);
      test_random(item_count + 8);
      write_reg(CSR_RETRY_LIMIT, 8'd255);
      write_reg(CSR_FRAME_ID, 8'h00);
      test_random(item_count + 8);
      write_reg(CSR_RETRY_LIMIT, 8'd2);
      write_reg(CSR_TS_FRAME_ID, $urandom);
      idle_on = 1'b0;
      test_random(item_count + 8);
      wait_drained();

      if (error_count == 0)
         $display("message_retry_queue_top test passed");
      else
         $display("message_retry_queue_top test failed");
      $finish;
   end
endmodule

[sim.f]
rtl/mrq_pkg.sv
rtl/mrq_front.sv
rtl/mrq_cmd_fifo.sv
rtl/mrq_back.sv
rtl/message_retry_queue_top.sv
rtl/mrq_checker.sv
tb/testbench.sv
